/* rtl/lcrt_pkg.sv */
package lcrt_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int ACC_W       = 40;
	localparam int DIFF_W      = SAMPLE_BITS + 1;
	localparam int GAIN_W      = 32;
	localparam int PROD_W      = DIFF_W + GAIN_W;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_READY_TMO    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP          = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN         = 3'd4;

	localparam logic [1:0] OP_NONE    = 2'd0;
	localparam logic [1:0] OP_AVERAGE = 2'd1;
	localparam logic [1:0] OP_TARE    = 2'd2;
	localparam logic [1:0] OP_WEIGH   = 2'd3;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [GAIN_W-1:0] gain_t;

	localparam sample_t SIGN_FLIP = 24'h800000;

	localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh80000000;

	localparam logic [15:0] CNT_RESET  = 16'd1;
	localparam logic [9:0]  HALF_RESET = 10'd8;
	localparam logic [9:0]  TMO_RESET  = 10'd150;
	localparam logic [7:0]  GAP_RESET  = 8'd5;
	localparam gain_t       GAIN_RESET = 32'sd65536;

endpackage

/* rtl/lcrt_div.sv */
module lcrt_div
	import lcrt_pkg::*;
#(
	parameter int DIVISOR_W = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [ACC_W-1:0]     dividend,
	input  logic [DIVISOR_W-1:0] divisor,
	output logic                 done,
	output logic [ACC_W-1:0]     quotient
);

	localparam int STEP_W = $clog2(ACC_W + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [STEP_W-1:0]    step_q;
	logic [ACC_W-1:0]     quo_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] dvs_q;

	logic [DIVISOR_W:0] trial;
	logic [DIVISOR_W:0] sub;
	logic               ge;

	assign trial = {rem_q, quo_q[ACC_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign sub   = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_W'(ACC_W);
			quo_q  <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			quo_q  <= {quo_q[ACC_W-2:0], ge};
			rem_q  <= ge ? sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			step_q <= step_q - STEP_W'(1);
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* rtl/lcrt_scale.sv */
module lcrt_scale
	import lcrt_pkg::*;
#(
	parameter int GAIN_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  diff_t       diff,
	input  gain_t       gain,
	output logic        done,
	output logic [31:0] weight
);

	localparam int SH_R   = (GAIN_FRAC_BITS > 16) ? GAIN_FRAC_BITS - 16 : 0;
	localparam int SH_L   = (GAIN_FRAC_BITS < 16) ? 16 - GAIN_FRAC_BITS : 0;
	localparam int WIDE_W = PROD_W + SH_L + 1;

	localparam logic signed [WIDE_W-1:0] W_MAX = WIDE_W'(Q_MAX);
	localparam logic signed [WIDE_W-1:0] W_MIN = WIDE_W'(Q_MIN);

	logic signed [PROD_W-1:0] prod_s1;
	logic                     vld_s1;
	logic [31:0]              weight_s2;
	logic                     vld_s2;

	logic signed [WIDE_W-1:0] wide;
	logic [31:0]              sat;

	// The right shift is arithmetic, so it rounds toward minus infinity.
	always_comb begin
		wide = $signed({{(WIDE_W - PROD_W){prod_s1[PROD_W-1]}}, prod_s1});
		wide = (wide <<< SH_L) >>> SH_R;
		if (wide > W_MAX) begin
			sat = Q_MAX;
		end else if (wide < W_MIN) begin
			sat = Q_MIN;
		end else begin
			sat = wide[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			prod_s1   <= '0;
			weight_s2 <= '0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			if (start) begin
				prod_s1 <= PROD_W'($signed(diff) * $signed(gain));
			end
			if (vld_s1) begin
				weight_s2 <= sat;
			end
		end
	end

	assign done   = vld_s2;
	assign weight = weight_s2;

endmodule

/* rtl/load_cell_reader_tare_weigh_core.sv */
// Load cell reader with tare and weighing for a 24-bit serial converter.
// Each item on the input channel (func, dout_level, ms_tick) is one tick of
// pin sampling, and every accepted item gives exactly one item on the output
// channel with the serial clock level, busy and done flags and the held
// average, weight, timeout flag and tare offset after that tick.
// A plain tick does not hold the input. The tick that ends an operation
// starts an iterative divider that retires one quotient bit per cycle, and
// a weigh operation then adds the registered multiply and the scaling and
// saturation stage.
// The input is not ready while the divider or scaler runs, or while an
// output item is still waiting and the receiver holds ready low.
// Configuration writes on the cfg channel are always accepted and land at
// once; they are meant to be written while the block is idle.
// Reset returns all registers to their defaults, clears the tare offset and
// held results, and leaves the block idle with the serial clock low.
module load_cell_reader_tare_weigh_core
	import lcrt_pkg::*;
#(
	parameter int COUNT_WIDTH    = 16,
	parameter int GAIN_FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            func,
	input  logic                  dout_level,
	input  logic                  ms_tick,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  sck_level,
	output logic                  busy_res,
	output logic                  done_res,
	output logic [23:0]           raw_average,
	output logic signed [31:0]    weight_q16,
	output logic                  timed_out,
	output logic [23:0]           offset_now
);

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_WAIT = 3'd1;
	localparam logic [2:0] PH_HIGH = 3'd2;
	localparam logic [2:0] PH_LOW  = 3'd3;
	localparam logic [2:0] PH_GAP  = 3'd4;

	localparam logic [1:0] CTL_RUN    = 2'd0;
	localparam logic [1:0] CTL_START  = 2'd1;
	localparam logic [1:0] CTL_DIVIDE = 2'd2;
	localparam logic [1:0] CTL_SCALE  = 2'd3;

	logic [15:0] cnt_cfg_q;
	logic [9:0]  half_cfg_q;
	logic [9:0]  tmo_cfg_q;
	logic [7:0]  gap_cfg_q;
	gain_t       gain_cfg_q;

	logic [1:0]             ctl_q;
	logic [2:0]             phase_q;
	logic [1:0]             op_q;
	logic [4:0]             bit_q;
	sample_t                shift_q;
	logic [9:0]             hb_q;
	logic [9:0]             ms_q;
	logic [COUNT_WIDTH-1:0] smp_q;
	logic [ACC_W-1:0]       acc_q;
	sample_t                tare_q;
	logic                   tmo_q;
	sample_t                avg_q;
	logic [31:0]            wgt_q;

	logic        out_valid_q;
	logic        out_sck_q;
	logic        out_busy_q;
	logic        out_done_q;
	sample_t     out_avg_q;
	logic [31:0] out_wgt_q;
	logic        out_tmo_q;
	sample_t     out_off_q;

	logic [2:0]             phase_d;
	logic [1:0]             op_d;
	logic [4:0]             bit_d;
	sample_t                shift_d;
	logic [9:0]             hb_d;
	logic [9:0]             ms_d;
	logic [COUNT_WIDTH-1:0] smp_d;
	logic [ACC_W-1:0]       acc_d;
	logic                   tmo_d;
	logic                   end_smp;
	sample_t                smp_val;
	logic                   finish;

	logic [9:0]             hb_inc;
	logic [9:0]             ms_gap;
	logic [9:0]             half_eff;
	logic [COUNT_WIDTH-1:0] smp_inc;
	logic [COUNT_WIDTH-1:0] target;
	logic                   accept;

	logic                   div_start;
	logic                   div_done;
	logic [ACC_W-1:0]       div_quo;
	logic [COUNT_WIDTH-1:0] div_dvs;
	sample_t                div_avg;
	logic                   scale_start;
	logic                   scale_done;
	logic [31:0]            scale_weight;
	diff_t                  scale_diff;

	assign cfg_ready = 1'b1;
	assign in_ready  = (ctl_q == CTL_RUN) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;

	assign hb_inc   = hb_q + 10'd1;
	assign ms_gap   = ms_tick ? ms_q + 10'd1 : ms_q;
	assign half_eff = (half_cfg_q == 10'd0) ? 10'd1 : half_cfg_q;
	assign smp_inc  = smp_q + COUNT_WIDTH'(1);
	assign target   = (cnt_cfg_q[COUNT_WIDTH-1:0] == '0) ? COUNT_WIDTH'(1)
	                                                     : cnt_cfg_q[COUNT_WIDTH-1:0];

	always_comb begin
		phase_d = phase_q;
		op_d    = op_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		hb_d    = hb_q;
		ms_d    = ms_q;
		smp_d   = smp_q;
		acc_d   = acc_q;
		tmo_d   = tmo_q;
		end_smp = 1'b0;
		smp_val = '0;
		finish  = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (func != OP_NONE) begin
					op_d    = func;
					smp_d   = '0;
					acc_d   = '0;
					tmo_d   = 1'b0;
					ms_d    = '0;
					phase_d = PH_WAIT;
				end
			end
			PH_WAIT: begin
				if (!dout_level) begin
					phase_d = PH_HIGH;
					bit_d   = '0;
					shift_d = '0;
					hb_d    = '0;
				end else if (ms_tick) begin
					if (ms_q >= tmo_cfg_q) begin
						tmo_d   = 1'b1;
						end_smp = 1'b1;
					end else begin
						ms_d = ms_q + 10'd1;
					end
				end
			end
			PH_HIGH: begin
				hb_d = hb_inc;
				if (hb_inc >= half_eff) begin
					hb_d    = '0;
					phase_d = PH_LOW;
				end
			end
			PH_LOW: begin
				hb_d = hb_inc;
				if (hb_inc >= half_eff) begin
					hb_d = '0;
					if (bit_q < 5'(SAMPLE_BITS)) begin
						shift_d = {shift_q[SAMPLE_BITS-2:0], dout_level};
						bit_d   = bit_q + 5'd1;
						phase_d = PH_HIGH;
					end else begin
						bit_d   = '0;
						end_smp = 1'b1;
						smp_val = shift_q ^ SIGN_FLIP;
					end
				end
			end
			PH_GAP: begin
				ms_d = ms_gap;
				if (ms_gap >= {2'b00, gap_cfg_q}) begin
					ms_d    = '0;
					phase_d = PH_WAIT;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
		if (end_smp) begin
			acc_d = acc_q + ACC_W'(smp_val);
			smp_d = smp_inc;
			if (smp_inc >= target) begin
				finish  = 1'b1;
				phase_d = PH_IDLE;
			end else begin
				phase_d = PH_GAP;
				ms_d    = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_cfg_q  <= CNT_RESET;
			half_cfg_q <= HALF_RESET;
			tmo_cfg_q  <= TMO_RESET;
			gap_cfg_q  <= GAP_RESET;
			gain_cfg_q <= GAIN_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SAMPLE_COUNT: cnt_cfg_q  <= cfg_data[15:0];
				CFG_HALF_BIT:     half_cfg_q <= cfg_data[9:0];
				CFG_READY_TMO:    tmo_cfg_q  <= cfg_data[9:0];
				CFG_GAP:          gap_cfg_q  <= cfg_data[7:0];
				CFG_GAIN:         gain_cfg_q <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q       <= CTL_RUN;
			phase_q     <= PH_IDLE;
			op_q        <= OP_NONE;
			bit_q       <= '0;
			shift_q     <= '0;
			hb_q        <= '0;
			ms_q        <= '0;
			smp_q       <= '0;
			acc_q       <= '0;
			tare_q      <= '0;
			tmo_q       <= 1'b0;
			avg_q       <= '0;
			wgt_q       <= '0;
			out_valid_q <= 1'b0;
			out_sck_q   <= 1'b0;
			out_busy_q  <= 1'b0;
			out_done_q  <= 1'b0;
			out_avg_q   <= '0;
			out_wgt_q   <= '0;
			out_tmo_q   <= 1'b0;
			out_off_q   <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (ctl_q)
				CTL_RUN: begin
					if (accept) begin
						phase_q <= phase_d;
						op_q    <= op_d;
						bit_q   <= bit_d;
						shift_q <= shift_d;
						hb_q    <= hb_d;
						ms_q    <= ms_d;
						smp_q   <= smp_d;
						acc_q   <= acc_d;
						tmo_q   <= tmo_d;
						if (finish) begin
							ctl_q <= CTL_START;
						end else begin
							out_valid_q <= 1'b1;
							out_sck_q   <= phase_d == PH_HIGH;
							out_busy_q  <= phase_d != PH_IDLE;
							out_done_q  <= 1'b0;
							out_avg_q   <= avg_q;
							out_wgt_q   <= wgt_q;
							out_tmo_q   <= tmo_d;
							out_off_q   <= tare_q;
						end
					end
				end
				CTL_START: begin
					ctl_q <= CTL_DIVIDE;
				end
				CTL_DIVIDE: begin
					if (div_done) begin
						avg_q <= div_avg;
						if (op_q == OP_WEIGH) begin
							ctl_q <= CTL_SCALE;
						end else begin
							if (op_q == OP_TARE) begin
								tare_q <= div_avg;
							end
							ctl_q       <= CTL_RUN;
							out_valid_q <= 1'b1;
							out_sck_q   <= 1'b0;
							out_busy_q  <= 1'b0;
							out_done_q  <= 1'b1;
							out_avg_q   <= div_avg;
							out_wgt_q   <= wgt_q;
							out_tmo_q   <= tmo_q;
							out_off_q   <= (op_q == OP_TARE) ? div_avg : tare_q;
						end
					end
				end
				CTL_SCALE: begin
					if (scale_done) begin
						wgt_q       <= scale_weight;
						ctl_q       <= CTL_RUN;
						out_valid_q <= 1'b1;
						out_sck_q   <= 1'b0;
						out_busy_q  <= 1'b0;
						out_done_q  <= 1'b1;
						out_avg_q   <= avg_q;
						out_wgt_q   <= scale_weight;
						out_tmo_q   <= tmo_q;
						out_off_q   <= tare_q;
					end
				end
				default: begin
					ctl_q <= CTL_RUN;
				end
			endcase
		end
	end

	assign div_start   = ctl_q == CTL_START;
	assign div_dvs     = (smp_q == '0) ? COUNT_WIDTH'(1) : smp_q;
	assign div_avg     = div_quo[SAMPLE_BITS-1:0];
	assign scale_start = (ctl_q == CTL_DIVIDE) && div_done && (op_q == OP_WEIGH);
	assign scale_diff  = $signed({1'b0, div_avg}) - $signed({1'b0, tare_q});

	lcrt_div #(
		.DIVISOR_W (COUNT_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_q),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	lcrt_scale #(
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scale_start),
		.diff   (scale_diff),
		.gain   (gain_cfg_q),
		.done   (scale_done),
		.weight (scale_weight)
	);

	assign out_valid   = out_valid_q;
	assign sck_level   = out_sck_q;
	assign busy_res    = out_busy_q;
	assign done_res    = out_done_q;
	assign raw_average = out_avg_q;
	assign weight_q16  = out_wgt_q;
	assign timed_out   = out_tmo_q;
	assign offset_now  = out_off_q;

endmodule

/* verif/load_cell_reader_tare_weigh_core_tb.sv */
`timescale 1ns / 100ps

module load_cell_reader_tare_weigh_core_tb;
	import lcrt_pkg::*;

	typedef enum logic [2:0] {
		RD_IDLE,
		RD_WAIT,
		RD_HIGH,
		RD_LOW,
		RD_GAP
	} reader_phase_e;

	typedef struct packed {
		logic        sck;
		logic        busy;
		logic        done;
		logic [23:0] average;
		logic [31:0] weight;
		logic        tmo;
		logic [23:0] offset;
	} reading_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_SAMPLE_COUNT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [1:0]            func = OP_NONE;
	logic                  dout_level = 1'b1;
	logic                  ms_tick = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  sck_level;
	logic                  busy_res;
	logic                  done_res;
	logic [23:0]           raw_average;
	logic signed [31:0]    weight_q16;
	logic                  timed_out;
	logic [23:0]           offset_now;

	// Register copies and reader state for the prediction.
	logic [15:0]   cnt_cfg = CNT_RESET;
	logic [9:0]    half_cfg = HALF_RESET;
	logic [9:0]    tmo_cfg = TMO_RESET;
	logic [7:0]    gap_cfg = GAP_RESET;
	gain_t         gain_cfg = GAIN_RESET;
	reader_phase_e phase_m = RD_IDLE;
	logic [1:0]    op_m = OP_NONE;
	logic [4:0]    nbits_m = '0;
	sample_t       shreg_m = '0;
	logic [9:0]    half_m = '0;
	logic [9:0]    ms_m = '0;
	logic [15:0]   taken_m = '0;
	logic [39:0]   sum_m = '0;
	sample_t       tare_m = '0;
	logic          tmo_m = 1'b0;
	sample_t       avg_m = '0;
	gain_t         weight_m = '0;

	reading_t expected_q[$];
	int       mismatches = 0;
	int       op_ticks = 0;
	int       ops_run = 0;
	bit       calm = 1'b0;

	load_cell_reader_tare_weigh_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.dout_level (dout_level),
		.ms_tick    (ms_tick),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sck_level  (sck_level),
		.busy_res   (busy_res),
		.done_res   (done_res),
		.raw_average(raw_average),
		.weight_q16 (weight_q16),
		.timed_out  (timed_out),
		.offset_now (offset_now)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Adds one conversion to the running sum; returns 1 when the operation ends.
	function automatic logic close_sample(sample_t value);
		logic [15:0] target;
		logic [15:0] n;
		sample_t     avg;
		longint      prod;
		sum_m = sum_m + {16'd0, value};
		taken_m = taken_m + 16'd1;
		target = (cnt_cfg == 16'd0) ? 16'd1 : cnt_cfg;
		if (taken_m < target) begin
			phase_m = RD_GAP;
			ms_m = '0;
			return 1'b0;
		end
		n = (taken_m == 16'd0) ? 16'd1 : taken_m;
		avg = 24'(sum_m / n);
		avg_m = avg;
		if (op_m == OP_TARE) begin
			tare_m = avg;
		end else if (op_m == OP_WEIGH) begin
			prod = (longint'(avg) - longint'(tare_m)) * longint'(gain_cfg);
			if (prod > longint'(Q_MAX))
				weight_m = Q_MAX;
			else if (prod < longint'(Q_MIN))
				weight_m = Q_MIN;
			else
				weight_m = 32'(prod);
		end
		phase_m = RD_IDLE;
		return 1'b1;
	endfunction

	function automatic reading_t scale_tick(logic [1:0] f, logic d, logic m);
		reading_t   r;
		logic       fin;
		logic [9:0] half_len;
		fin = 1'b0;
		half_len = (half_cfg == 10'd0) ? 10'd1 : half_cfg;
		case (phase_m)
			RD_IDLE: begin
				if (f != OP_NONE) begin
					op_m = f;
					taken_m = '0;
					sum_m = '0;
					tmo_m = 1'b0;
					ms_m = '0;
					phase_m = RD_WAIT;
				end
			end
			RD_WAIT: begin
				if (!d) begin
					phase_m = RD_HIGH;
					nbits_m = '0;
					shreg_m = '0;
					half_m = '0;
				end else if (m) begin
					if (ms_m >= tmo_cfg) begin
						tmo_m = 1'b1;
						fin = close_sample('0);
					end else begin
						ms_m = ms_m + 10'd1;
					end
				end
			end
			RD_HIGH: begin
				half_m = half_m + 10'd1;
				if (half_m >= half_len) begin
					half_m = '0;
					phase_m = RD_LOW;
				end
			end
			RD_LOW: begin
				half_m = half_m + 10'd1;
				if (half_m >= half_len) begin
					half_m = '0;
					if (nbits_m < SAMPLE_BITS) begin
						shreg_m = {shreg_m[SAMPLE_BITS-2:0], d};
						nbits_m = nbits_m + 5'd1;
						phase_m = RD_HIGH;
					end else begin
						nbits_m = '0;
						fin = close_sample(shreg_m ^ SIGN_FLIP);
					end
				end
			end
			RD_GAP: begin
				if (m)
					ms_m = ms_m + 10'd1;
				if (ms_m >= {2'b00, gap_cfg}) begin
					ms_m = '0;
					phase_m = RD_WAIT;
				end
			end
			default: begin
				phase_m = RD_IDLE;
			end
		endcase
		r.sck = (phase_m == RD_HIGH);
		r.busy = (phase_m != RD_IDLE);
		r.done = fin;
		r.average = avg_m;
		r.weight = weight_m;
		r.tmo = tmo_m;
		r.offset = tare_m;
		return r;
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 200)
				$display("%0t: %s expected %h, got %h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		reading_t got;
		reading_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {sck_level, busy_res, done_res, raw_average, weight_q16, timed_out, offset_now};
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 200)
					$display("%0t: unexpected item, expected none, got %h", $time, got);
			end else begin
				want = expected_q.pop_front();
				compare_field("sck_level", want.sck, got.sck);
				compare_field("busy_res", want.busy, got.busy);
				compare_field("done_res", want.done, got.done);
				compare_field("raw_average", want.average, got.average);
				compare_field("weight_q16", want.weight, got.weight);
				compare_field("timed_out", want.tmo, got.tmo);
				compare_field("offset_now", want.offset, got.offset);
			end
		end
		out_ready <= calm || ($urandom_range(0, 99) >= 30);
	end

	task automatic send_tick(input logic [1:0] f, input logic d, input logic m);
		if (!calm) begin
			while ($urandom_range(0, 99) < 30) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		expected_q.push_back(scale_tick(f, d, m));
		in_valid <= 1'b1;
		func <= f;
		dout_level <= d;
		ms_tick <= m;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_SAMPLE_COUNT: cnt_cfg = val[15:0];
			CFG_HALF_BIT:     half_cfg = val[9:0];
			CFG_READY_TMO:    tmo_cfg = val[9:0];
			CFG_GAP:          gap_cfg = val[7:0];
			CFG_GAIN:         gain_cfg = val;
			default:          ;
		endcase
	endtask

	task automatic load_settings(input logic [15:0] cnt, input logic [9:0] half,
			input logic [9:0] tmo, input logic [7:0] gap, input gain_t gain);
		settle();
		write_reg(CFG_SAMPLE_COUNT, {16'($urandom), cnt});
		write_reg(CFG_HALF_BIT, {22'($urandom), half});
		write_reg(CFG_READY_TMO, {22'($urandom), tmo});
		write_reg(CFG_GAP, {24'($urandom), gap});
		write_reg(CFG_GAIN, gain);
		cfg_valid <= 1'b0;
	endtask

	// One operation from request to completion. The pin answers ready with the
	// given chance per thousand ticks and presents the sample word bit by bit.
	task automatic run_op(input logic [1:0] op, input int ready_pm, input int ms_pct,
			input sample_t word, input bit fresh_words);
		sample_t bits_now;
		logic    d;
		bits_now = fresh_words ? 24'($urandom) : word;
		send_tick(op, 1'($urandom), 1'($urandom));
		op_ticks++;
		while (phase_m != RD_IDLE) begin
			case (phase_m)
				RD_WAIT: d = ($urandom_range(0, 999) < ready_pm) ? 1'b0 : 1'b1;
				RD_LOW:  d = (nbits_m < SAMPLE_BITS) ?
						bits_now[SAMPLE_BITS - 1 - nbits_m] : 1'($urandom);
				default: d = 1'($urandom);
			endcase
			if (phase_m == RD_GAP && fresh_words)
				bits_now = 24'($urandom);
			send_tick(2'($urandom), d, $urandom_range(0, 99) < ms_pct);
			op_ticks++;
		end
		ops_run++;
	endtask

	task automatic test_reset_defaults();
		repeat (4) send_tick(OP_NONE, 1'($urandom), 1'($urandom));
		settle();
		write_reg(CFG_HALF_BIT, 32'd1);
		cfg_valid <= 1'b0;
		run_op(OP_WEIGH, 1000, 50, 24'h000000, 1'b1);
	endtask

	task automatic test_directed_ops();
		load_settings(16'd1, 10'd1, 10'd2, 8'd0, 32'sd65536);
		run_op(OP_AVERAGE, 1000, 50, 24'hFFFFFF, 1'b0);
		run_op(OP_TARE, 1000, 50, 24'h7FFFFF, 1'b0);
		run_op(OP_WEIGH, 1000, 50, 24'h800000, 1'b0);
		run_op(OP_WEIGH, 0, 100, 24'h000000, 1'b0);
		repeat (4) send_tick(OP_NONE, 1'($urandom), 1'($urandom));
		load_settings(16'd3, 10'd0, 10'd1, 8'd1, -32'sd65536);
		run_op(OP_TARE, 0, 60, 24'h000000, 1'b0);
		load_settings(16'd2, 10'd1, 10'd2, 8'd1, 32'sd3);
		run_op(OP_WEIGH, 500, 50, 24'h000000, 1'b1);
	endtask

	task automatic test_register_extremes();
		calm = 1'b1;
		load_settings(16'd0, 10'd1, 10'd1023, 8'd255, Q_MAX);
		run_op(OP_WEIGH, 1000, 100, 24'h5A5A5A, 1'b0);
		calm = 1'b0;
	endtask

	task automatic test_random_ops();
		int    stop_at;
		int    ops_goal;
		int    ready_pm;
		gain_t gain;
		stop_at = op_ticks + 40;
		ops_goal = ops_run + 2;
		while (op_ticks < stop_at || ops_run < ops_goal) begin
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 3))
					0: gain = gain_t'($urandom);
					1: gain = gain_t'($urandom_range(0, 400)) - 32'sd200;
					2: gain = Q_MAX;
					default: gain = Q_MIN;
				endcase
				load_settings(16'($urandom_range(1, 2)), 10'($urandom_range(0, 1)),
						10'($urandom_range(0, 2)), 8'($urandom_range(0, 2)), gain);
			end
			calm = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 4))
					send_tick(OP_NONE, 1'($urandom), 1'($urandom));
			end else begin
				case ($urandom_range(0, 3))
					0: ready_pm = 0;
					1: ready_pm = 150;
					2: ready_pm = 500;
					default: ready_pm = 1000;
				endcase
				run_op(2'($urandom_range(1, 3)), ready_pm, $urandom_range(20, 100),
						24'($urandom), 1'($urandom));
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed_ops();
		test_register_extremes();
		test_random_ops();
		settle();
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
